### rtl/core/connection_handle_table_top_defines.svh
// ---------------------------------------------------------------------------
// Connection handle table assertion macros
// Shared concurrent-assertion wrappers, clocked on clk_i, off during reset.
// ---------------------------------------------------------------------------
`ifndef CONNECTION_HANDLE_TABLE_TOP_DEFINES_SVH
`define CONNECTION_HANDLE_TABLE_TOP_DEFINES_SVH

// property must hold at every edge out of reset
`define CHT_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// expression must never be true out of reset
`define CHT_ASSERT_NEVER(name, expr, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

### rtl/core/cht_pkg.sv
// ---------------------------------------------------------------------------
// Connection handle table package
// Word layouts, op and status codes, controller/datapath interface types.
// ---------------------------------------------------------------------------
package cht_pkg;

  // handle layout: slot 31:24, tag 23:16, low bits zero
  localparam int unsigned SLOT_LSB     = 24;
  localparam int unsigned SLOT_FIELD_W = 8;
  localparam int unsigned TAG_LSB      = 16;
  localparam int unsigned TAG_W        = 8;
  localparam int unsigned HANDLE_LOW_W = 16;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_RESOLVE = 2'd1,
    OP_REMOVE  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2
  } status_e;

  // input word, first field in the highest bits
  typedef struct packed {
    logic [TAG_W-1:0] rand_tag;
    logic [63:0]      session_id;
    logic [31:0]      online_id_lo;
    logic [63:0]      online_id_mid;
    logic [63:0]      online_id_hi;
    logic [47:0]      mac;
    logic [15:0]      port_online;
    logic [31:0]      addr_online;
    logic [31:0]      addr_lan;
    logic [31:0]      handle_in;
  } in_word_t;

  // result word, first field in the highest bits
  typedef struct packed {
    logic [63:0] session_out;
    logic [31:0] res_online_id_lo;
    logic [63:0] res_online_id_mid;
    logic [63:0] res_online_id_hi;
    logic [47:0] res_mac;
    logic [15:0] res_port_online;
    logic [31:0] res_addr_online;
    logic [31:0] res_addr_lan;
    logic [31:0] handle_out;
  } out_word_t;

  // 288-bit peer address key
  typedef struct packed {
    logic [31:0] oid_lo;
    logic [63:0] oid_mid;
    logic [63:0] oid_hi;
    logic [47:0] mac;
    logic [15:0] port;
    logic [31:0] online;
    logic [31:0] lan;
  } key_t;

  // one entry of the table memory
  typedef struct packed {
    logic [63:0]      session;
    logic [TAG_W-1:0] tag;
    key_t             key;
  } entry_t;

  localparam int unsigned IN_W  = $bits(in_word_t);
  localparam int unsigned OUT_W = $bits(out_word_t);

  typedef struct packed {
    logic load;     // capture the input word, clear search flags
    logic scan_rd;  // read entry at scan counter, advance counter
    logic look_rd;  // read entry named by the handle
    logic finish;   // update table, load result register
  } cht_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       scan_last;
    logic       out_free;
  } cht_stat_t;

endpackage

### rtl/core/cht_ctrl.sv
// ---------------------------------------------------------------------------
// Connection handle table controller
// Sequences capture, entry scan or handle lookup, and result hand-off.
// ---------------------------------------------------------------------------
module cht_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  cht_pkg::cht_stat_t  stat_i,
  output cht_pkg::cht_cmd_t   cmd_o
);
  import cht_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DISP = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_WAIT = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISP;
        end
      end
      S_DISP: begin
        case (stat_i.op) inside
          OP_INSERT: begin
            cmd_o.scan_rd = 1'b1;
            state_d       = stat_i.scan_last ? S_WAIT : S_SCAN;
          end
          OP_RESOLVE, OP_REMOVE: begin
            cmd_o.look_rd = 1'b1;
            state_d       = S_WAIT;
          end
          default: begin
            state_d = S_FIN;
          end
        endcase
      end
      S_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (stat_i.scan_last) begin
          state_d = S_WAIT;
        end
      end
      S_WAIT: begin
        state_d = S_FIN;
      end
      S_FIN: begin
        if (stat_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/core/cht_dpath.sv
// ---------------------------------------------------------------------------
// Connection handle table datapath
// Entry memory, valid bits, compare stage, search flags, result register.
// ---------------------------------------------------------------------------
module cht_dpath #(
  parameter int unsigned ENTRY_COUNT = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cht_pkg::cht_cmd_t         cmd_i,
  output cht_pkg::cht_stat_t        stat_o,
  input  logic [cht_pkg::IN_W-1:0]  in_data_i,
  input  logic [1:0]                in_user_i,
  input  logic                      cfg_valid_i,
  input  logic [63:0]               cfg_data_i,
  input  logic                      out_ready_i,
  output logic                      out_valid_o,
  output logic [cht_pkg::OUT_W-1:0] out_data_o,
  output logic [1:0]                out_user_o
);
  import cht_pkg::*;

  localparam int unsigned SLOT_W = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;

  entry_t mem_q [ENTRY_COUNT];
  entry_t rdata_q;

  logic [ENTRY_COUNT-1:0] valid_q;
  in_word_t               item_q;
  logic [1:0]             op_q;
  logic [SLOT_W-1:0]      cnt_q;
  logic [SLOT_W-1:0]      rd_addr_q;
  logic                   pend_q;
  logic                   hit_q;
  logic [SLOT_W-1:0]      hit_slot_q;
  logic [TAG_W-1:0]       hit_tag_q;
  logic                   free_q;
  logic [SLOT_W-1:0]      free_slot_q;
  logic [63:0]            host_session_q;
  logic                   out_valid_q;
  out_word_t              out_data_q;
  logic [1:0]             out_user_q;

  key_t                   item_key;
  entry_t                 new_entry;
  logic [SLOT_FIELD_W-1:0] h_slot;
  logic [TAG_W-1:0]       h_tag;
  logic                   slot_ok;
  logic                   rd_en;
  logic [SLOT_W-1:0]      rd_addr;
  logic                   ent_valid;
  logic                   key_eq;
  logic                   handle_eq;
  out_word_t              res_d;
  status_e                status_d;

  always_comb begin
    item_key.lan    = item_q.addr_lan;
    item_key.online = item_q.addr_online;
    item_key.port   = item_q.port_online;
    item_key.mac    = item_q.mac;
    item_key.oid_hi = item_q.online_id_hi;
    item_key.oid_mid = item_q.online_id_mid;
    item_key.oid_lo = item_q.online_id_lo;
    new_entry.key     = item_key;
    new_entry.tag     = item_q.rand_tag;
    new_entry.session = item_q.session_id;
  end

  assign h_slot  = item_q.handle_in[SLOT_LSB +: SLOT_FIELD_W];
  assign h_tag   = item_q.handle_in[TAG_LSB +: TAG_W];
  assign slot_ok = ({1'b0, h_slot} < (SLOT_FIELD_W + 1)'(ENTRY_COUNT));

  // one read port: scan counter for insert, handle slot for lookups
  assign rd_en   = cmd_i.scan_rd | (cmd_i.look_rd & slot_ok);
  assign rd_addr = cmd_i.scan_rd ? cnt_q : h_slot[SLOT_W-1:0];

  // compare stage on registered read data
  assign ent_valid = valid_q[rd_addr_q];
  assign key_eq    = (rdata_q.key == item_key);
  assign handle_eq = slot_ok && (rdata_q.tag == h_tag) &&
                     (item_q.handle_in[HANDLE_LOW_W-1:0] == '0);

  assign stat_o.op        = op_q;
  assign stat_o.scan_last = (cnt_q == SLOT_W'(ENTRY_COUNT - 1));
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  // result assembly
  always_comb begin
    res_d    = '0;
    status_d = STAT_NOT_FOUND;
    case (op_q)
      OP_INSERT: begin
        if (hit_q) begin
          status_d         = STAT_OK;
          res_d.handle_out = {SLOT_FIELD_W'(hit_slot_q), hit_tag_q,
                              {HANDLE_LOW_W{1'b0}}};
        end else if (free_q) begin
          status_d         = STAT_OK;
          res_d.handle_out = {SLOT_FIELD_W'(free_slot_q), item_q.rand_tag,
                              {HANDLE_LOW_W{1'b0}}};
        end else begin
          status_d = STAT_FULL;
        end
      end
      OP_RESOLVE: begin
        if (hit_q) begin
          status_d                = STAT_OK;
          res_d.res_addr_lan      = rdata_q.key.lan;
          res_d.res_addr_online   = rdata_q.key.online;
          res_d.res_port_online   = rdata_q.key.port;
          res_d.res_mac           = rdata_q.key.mac;
          res_d.res_online_id_hi  = rdata_q.key.oid_hi;
          res_d.res_online_id_mid = rdata_q.key.oid_mid;
          res_d.res_online_id_lo  = rdata_q.key.oid_lo;
          res_d.session_out       = host_session_q;
        end
      end
      OP_REMOVE: begin
        if (hit_q) begin
          status_d = STAT_OK;
        end
      end
      default: begin
        status_d = STAT_NOT_FOUND;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q        <= '0;
      cnt_q          <= '0;
      pend_q         <= 1'b0;
      hit_q          <= 1'b0;
      free_q         <= 1'b0;
      host_session_q <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      pend_q <= rd_en;
      if (cfg_valid_i) begin
        host_session_q <= cfg_data_i;
      end
      if (cmd_i.load) begin
        cnt_q  <= '0;
        hit_q  <= 1'b0;
        free_q <= 1'b0;
      end else begin
        if (cmd_i.scan_rd) begin
          cnt_q <= cnt_q + 1'b1;
        end
        if (pend_q) begin
          if (op_q == OP_INSERT) begin
            if (ent_valid && key_eq) begin
              hit_q <= 1'b1;
            end
            if (!ent_valid) begin
              free_q <= 1'b1;
            end
          end else begin
            hit_q <= ent_valid && handle_eq;
          end
        end
      end
      if (cmd_i.finish) begin
        if (op_q == OP_INSERT && !hit_q && free_q) begin
          valid_q[free_slot_q] <= 1'b1;
        end
        if (op_q == OP_REMOVE && hit_q) begin
          valid_q[hit_slot_q] <= 1'b0;
        end
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload and search positions
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_word_t'(in_data_i);
      op_q   <= in_user_i;
    end
    if (rd_en) begin
      rd_addr_q <= rd_addr;
    end
    if (pend_q && !cmd_i.load) begin
      if (op_q == OP_INSERT) begin
        if (ent_valid && key_eq && !hit_q) begin
          hit_slot_q <= rd_addr_q;
          hit_tag_q  <= rdata_q.tag;
        end
        if (!ent_valid && !free_q) begin
          free_slot_q <= rd_addr_q;
        end
      end else begin
        hit_slot_q <= rd_addr_q;
      end
    end
    if (cmd_i.finish) begin
      out_data_q <= res_d;
      out_user_q <= status_d;
    end
  end

  // entry memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish && op_q == OP_INSERT && !hit_q && free_q) begin
      mem_q[free_slot_q] <= new_entry;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_user_o  = out_user_q;

endmodule

### rtl/core/connection_handle_table_top.sv
// ---------------------------------------------------------------------------
// Connection handle table
// Peer-address table issuing 32-bit handles: insert/find, resolve, remove.
// ---------------------------------------------------------------------------
//
//  channel   dir  signals                        word
//  s_axis    in   tvalid/tready, tdata, tuser     one request (op in tuser)
//  m_axis    out  tvalid/tready, tdata, tuser     one result (status in tuser)
//  cfg       in   cfg_valid/cfg_ready, cfg_data   host session id, always ready
//
//  Insert: the key scan reads every entry, then the result is loaded;
//  the next word is taken only once the previous one is finished. The
//  entry memory has a single read port, so the key scan visits one
//  entry per cycle. Resolve/remove: one handle lookup; unused op 3.
//  Reset clears all valid bits and the host session id at once, no sweep.
//  A held result stalls only the final step; the next word is taken while a
//  result still waits on m_axis.
//
`include "connection_handle_table_top_defines.svh"

module connection_handle_table_top #(
  parameter int unsigned ENTRY_COUNT = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // request: handle_in, addr_lan, addr_online, port_online, mac,
  //          online_id_hi, online_id_mid, online_id_lo, session_id, rand_tag
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  logic [cht_pkg::IN_W-1:0]  s_axis_tdata_i,
  input  logic [1:0]                s_axis_tuser_i,   // op
  // result: handle_out, res_addr_lan, res_addr_online, res_port_online,
  //         res_mac, res_online_id_hi, res_online_id_mid, res_online_id_lo,
  //         session_out
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  output logic [cht_pkg::OUT_W-1:0] m_axis_tdata_o,
  output logic [1:0]                m_axis_tuser_o,   // status
  // host session id register
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [63:0]               cfg_data_i
);
  import cht_pkg::*;

  cht_cmd_t  cmd;
  cht_stat_t stat;

  assign cfg_ready_o = 1'b1;

  // sequencer: capture, scan or lookup, hand-off
  cht_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // table storage, compare and result register
  cht_dpath #(
    .ENTRY_COUNT (ENTRY_COUNT)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_data_i   (s_axis_tdata_i),
    .in_user_i   (s_axis_tuser_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_data_o  (m_axis_tdata_o),
    .out_user_o  (m_axis_tuser_o)
  );

  // a taken request always moves the controller out of idle
  `CHT_ASSERT(a_accept_leaves_idle, s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o, "request accepted but controller stayed idle")

  // a new result appears only through the finish step
  `CHT_ASSERT(a_result_from_finish, $rose(m_axis_tvalid_o) |-> $past(cmd.finish), "result raised without finish command")

  // failed requests carry an all-zero payload
  `CHT_ASSERT_NEVER(a_fail_payload_zero, m_axis_tvalid_o && m_axis_tuser_o != STAT_OK && m_axis_tdata_o != '0, "nonzero payload on failed result")

endmodule
